@@ src/hdb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hdb_pkg;

  // Height samples use the low nibble of each input word.
  localparam int HEIGHT_BITS  = 4;
  localparam int HEIGHT_SHIFT = 3;

  // Row count limits and field widths fixed by the stream format.
  localparam int HEIGHT_LIMIT = 1024;
  localparam int CFG_W        = 11;
  localparam int POS_W        = 10;
  localparam int DIFF_W       = 8;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;

  // Depth of the pixel record queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Kinds of result one pixel can cause, in emission order.
  // Each value is also the bit position in a record's result mask.
  typedef enum logic [1:0] {
    RES_UPLEFT    = 2'd0,
    RES_ROW_END   = 2'd1,
    RES_LAST_ROW  = 2'd2,
    RES_FRAME_END = 2'd3
  } res_kind_t;

  // One accepted pixel with the neighborhood needed for its results.
  typedef struct packed {
    logic [3:0]             mask;
    logic [POS_W-1:0]       col;
    logic [POS_W-1:0]       row;
    logic [HEIGHT_BITS-1:0] ulh;
    logic [HEIGHT_BITS-1:0] up;
    logic [HEIGHT_BITS-1:0] lh;
    logic [HEIGHT_BITS-1:0] cur;
  } hdb_rec_t;

  // Scaled difference of two heights as a two's complement byte.
  function automatic logic [DIFF_W-1:0] hdb_diff(input logic [HEIGHT_BITS-1:0] a,
                                                 input logic [HEIGHT_BITS-1:0] b);
    logic [HEIGHT_BITS:0] d;
    d = {1'b0, a} - {1'b0, b};
    return {d, {HEIGHT_SHIFT{1'b0}}};
  endfunction

endpackage

`default_nettype wire

@@ src/heightmap_to_dudv_bump.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Heightmap to du/dv bump converter. Height words arrive in raster order, one
// per transaction, and the low nibble of each, scaled by 8, is the height.
// Every pixel yields a forward difference pair (du to the right, dv
// downward), with the last column and last row differencing against
// themselves. A line store of MAX_WIDTH entries holds the previous row, so a
// pixel's result leaves roughly one row and one column after it arrives,
// tagged with its column, row and tlast on the final pixel of the frame. The
// block takes one pixel per clock and emits one result per clock, while the
// sink is ready, from an output register; the line store's single read port,
// read and written once per pixel, sets that input rate. Row ends produce extra
// results, and a four-entry record queue absorbs those bursts, dropping
// s_axis_tready while it is close to full. On the last row most pixels yield
// two results, so the input there runs at half rate once the queue has filled.
// A pixel passes the read stage, the record queue and the current-record
// register before it reaches the output register. A register write restarts
// the frame at column 0, row 0; the line store needs no clearing after reset.
module heightmap_to_dudv_bump #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // height_word[15:0]
  input  wire logic [hdb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // du[7:0], dv[15:8], out_col[25:16], out_row[35:26], zero fill [39:36]
  output logic [hdb_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // frame_done
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [hdb_pkg::CFG_W-1:0]        cfg_data
);
  import hdb_pkg::*;

  logic              push;
  hdb_rec_t          push_rec;
  logic              q_pop;
  logic              q_valid;
  hdb_rec_t          q_rec;
  logic [QCNT_W-1:0] q_free;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  hdb_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_free       (q_free),
    .push         (push),
    .push_rec     (push_rec)
  );

  hdb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .q_free  (q_free)
  );

  hdb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rec        (q_rec),
    .q_pop        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // The read stage never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> (q_free != '0))
    else $error("record queue overflow");

  // The back part only takes records that are present.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("record queue underflow");

  // The frame's final result is the bottom-right pixel with zero differences.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[15:0] == 16'h0000))
    else $error("frame end result carries nonzero differences");
`endif

endmodule

`default_nettype wire

@@ src/hdb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hdb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ src/hdb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hdb_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [hdb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             cfg_valid,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [hdb_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [hdb_pkg::QCNT_W-1:0]       q_free,
  output logic                                  push,
  output hdb_pkg::hdb_rec_t                     push_rec
);
  import hdb_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RESET_W = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;

  logic [WW-1:0]          width_eff;
  logic [CFG_W-1:0]       height_eff;
  logic [AW-1:0]          col;
  logic [POS_W-1:0]       row;

  logic                   accept;
  logic [HEIGHT_BITS-1:0] cur;
  logic [WW-1:0]          col_inc;
  logic [CFG_W-1:0]       row_inc;
  logic                   col_last;
  logic                   row_last;
  logic [3:0]             mask_next;

  logic                   b_valid;
  logic [HEIGHT_BITS-1:0] b_cur;
  logic [POS_W-1:0]       b_col;
  logic [POS_W-1:0]       b_row;
  logic [3:0]             b_mask;
  logic [HEIGHT_BITS-1:0] up;
  logic [HEIGHT_BITS-1:0] lh;
  logic [HEIGHT_BITS-1:0] ulh;

  // Room is kept for the record already on its way out of the read stage.
  assign s_axis_tready = q_free > QCNT_W'(b_valid);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cur           = s_axis_tdata[HEIGHT_BITS-1:0];

  // Position of this pixel against the frame edges.
  always_comb begin
    col_inc  = WW'(col) + WW'(1);
    row_inc  = CFG_W'(row) + CFG_W'(1);
    col_last = col_inc == width_eff;
    row_last = row_inc == height_eff;
    mask_next                = '0;
    mask_next[RES_UPLEFT]    = (col != '0) && (row != '0);
    mask_next[RES_ROW_END]   = col_last && (row != '0);
    mask_next[RES_LAST_ROW]  = row_last && (col != '0);
    mask_next[RES_FRAME_END] = row_last && col_last;
  end

  // Configuration registers and the raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(RESET_W);
      height_eff <= CFG_W'(256);
      col        <= '0;
      row        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (cfg_data == '0) begin
            width_eff <= WW'(1);
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            width_eff <= WW'(MAX_WIDTH);
          end else begin
            width_eff <= WW'(cfg_data);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data == '0) begin
            height_eff <= CFG_W'(1);
          end else if (32'(cfg_data) > HEIGHT_LIMIT) begin
            height_eff <= CFG_W'(HEIGHT_LIMIT);
          end else begin
            height_eff <= cfg_data;
          end
        end
        default: begin
        end
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + POS_W'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // Line store of the previous row, read and overwritten at the same column.
  hdb_ram #(
    .WIDTH(HEIGHT_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (accept),
    .waddr(col),
    .wdata(cur),
    .raddr(col),
    .rdata(up)
  );

  // Read stage: holds the pixel while the line store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
    if (accept) begin
      b_cur  <= cur;
      b_col  <= POS_W'(col);
      b_row  <= row;
      b_mask <= mask_next;
    end
  end

  // Left and upper-left heights follow the pixel leaving the read stage.
  always_ff @(posedge clk) begin
    if (rst || cfg_valid) begin
      lh  <= '0;
      ulh <= '0;
    end else if (b_valid) begin
      lh  <= b_cur;
      ulh <= up;
    end
  end

  // Pixels that cause no result are dropped here.
  assign push = b_valid && (b_mask != '0);

  always_comb begin
    push_rec.mask = b_mask;
    push_rec.col  = b_col;
    push_rec.row  = b_row;
    push_rec.ulh  = ulh;
    push_rec.up   = up;
    push_rec.lh   = lh;
    push_rec.cur  = b_cur;
  end

endmodule

`default_nettype wire

@@ src/hdb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hdb_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  hdb_pkg::hdb_rec_t               push_rec,
  input  wire logic                       pop,
  output logic                            q_valid,
  output hdb_pkg::hdb_rec_t               q_rec,
  output logic [hdb_pkg::QCNT_W-1:0]      q_free
);
  import hdb_pkg::*;

  hdb_rec_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_valid = count != '0;
  assign q_rec   = slots[rd_ptr];
  assign q_free  = QCNT_W'(QUEUE_DEPTH) - count;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

@@ src/hdb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hdb_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  hdb_pkg::hdb_rec_t                    q_rec,
  output logic                                 q_pop,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [hdb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import hdb_pkg::*;

  hdb_rec_t         rec;
  logic [3:0]       pend;
  logic [3:0]       pend_after;
  logic             slot_free;
  logic             emit;
  res_kind_t        kind;
  logic [DIFF_W-1:0] du;
  logic [DIFF_W-1:0] dv;
  logic [POS_W-1:0] res_col;
  logic [POS_W-1:0] res_row;
  logic             res_last;

  // Lowest pending result of the current record goes first.
  always_comb begin
    if (pend[RES_UPLEFT]) begin
      kind = RES_UPLEFT;
    end else if (pend[RES_ROW_END]) begin
      kind = RES_ROW_END;
    end else if (pend[RES_LAST_ROW]) begin
      kind = RES_LAST_ROW;
    end else begin
      kind = RES_FRAME_END;
    end
  end

  assign slot_free  = !m_axis_tvalid || m_axis_tready;
  assign emit       = (pend != '0) && slot_free;
  assign pend_after = emit ? (pend & ~(4'(1) << kind)) : pend;
  assign q_pop      = q_valid && (pend_after == '0);

  // Result fields for the selected kind.
  always_comb begin
    du       = '0;
    dv       = '0;
    res_col  = rec.col;
    res_row  = rec.row;
    res_last = 1'b0;
    case (kind)
      RES_UPLEFT: begin
        du      = hdb_diff(rec.ulh, rec.up);
        dv      = hdb_diff(rec.ulh, rec.lh);
        res_col = rec.col - POS_W'(1);
        res_row = rec.row - POS_W'(1);
      end
      RES_ROW_END: begin
        dv      = hdb_diff(rec.up, rec.cur);
        res_row = rec.row - POS_W'(1);
      end
      RES_LAST_ROW: begin
        du      = hdb_diff(rec.lh, rec.cur);
        res_col = rec.col - POS_W'(1);
      end
      RES_FRAME_END: begin
        res_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Current record and its pending result mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (q_pop) begin
      pend <= q_rec.mask;
    end else begin
      pend <= pend_after;
    end
    if (q_pop) begin
      rec <= q_rec;
    end
  end

  // Output register: the next result loads as the held one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (emit) begin
      m_axis_tdata <= {4'b0000, res_row, res_col, dv, du};
      m_axis_tlast <= res_last;
    end
  end

endmodule

`default_nettype wire
